@@ hdl/ditc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ditc_pkg
// Shared types, constants and the digit encoder for int_to_digit_string.
// ----------------------------------------------------------------------------
package ditc_pkg;

   localparam int BASE_W = 6;
   localparam int CHAR_W = 8;
   localparam int TLEN_W = 6;

   localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] BASE_TEN   = 6'd10;
   localparam logic [BASE_W-1:0] DIGIT_NINE = 6'd9;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWA  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

   // register index of number_base
   localparam logic REG_NUMBER_BASE = 1'b0;

   typedef logic [BASE_W-1:0] digit_type;

   // map a digit value to its ASCII character
   function automatic logic [CHAR_W-1:0] digit_char(input digit_type d);
      logic [CHAR_W-1:0] c;
      if (d > DIGIT_NINE) begin
         c = CHAR_LOWA + {2'b00, d} - {2'b00, BASE_TEN};
      end else begin
         c = CHAR_ZERO + {2'b00, d};
      end
      return c;
   endfunction

endpackage

@@ hdl/int_to_digit_string.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_digit_string
// Converts a signed integer to its ASCII digit string in a configurable base.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel takes one VALUE_WIDTH-bit value per transaction.
//  - rsp_ channel returns a run of characters: NUL, digits least significant
//    first, then '-' for a negative value in base ten. The final character
//    has rsp_is_last set and carries the run length in rsp_total_length.
//  - csr_ port holds number_base at address 0 (saturated to 2..36 on use).
//  - Conversion uses a row of VALUE_WIDTH digit cells fed one value bit per
//    cycle, MSB first; carries travel one cell per cycle.
//  - Emission then sends the characters one by one through the output
//    register (2 to VALUE_WIDTH+1 of them), and the next value is accepted
//    once the last character is in the output register.
//  - A stalled receiver holds the output register and the emission sequence.
//  - Reset empties the output, returns to idle and sets number_base to 10.
// ----------------------------------------------------------------------------
module int_to_digit_string
   import ditc_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [VALUE_WIDTH-1:0]  req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CHAR_W-1:0]       rsp_character,
   output logic                    rsp_is_last,
   output logic [TLEN_W-1:0]       rsp_total_length,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int CNT_W = $clog2(2*VALUE_WIDTH);
   localparam int ND_W  = $clog2(VALUE_WIDTH+1);
   localparam int IDX_W = $clog2(VALUE_WIDTH+3);
   localparam logic [CNT_W-1:0] CNT_FEED_END = CNT_W'(VALUE_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(2*VALUE_WIDTH-1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   minus_ff, minus_in;
   digit_type              base_ff, base_in;
   digit_type              cfg_base_ff, cfg_base_in;
   logic [ND_W-1:0]        ndig_ff, ndig_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] runsh_ff;
   logic [VALUE_WIDTH-1:0] run, fin, nz;
   logic [VALUE_WIDTH-1:0] carry;
   digit_type              digits [VALUE_WIDTH];
   logic                   rvalid_ff, rvalid_in;
   logic [CHAR_W-1:0]      rchar_ff, rchar_in;
   logic                   rlast_ff, rlast_in;
   logic [TLEN_W-1:0]      rlen_ff, rlen_in;

   logic                   accept, out_free, start, shift, cfg_wr;
   logic [VALUE_WIDTH-1:0] neg_val;
   digit_type              cfg_sat;
   logic [ND_W-1:0]        nd_eff;
   logic [IDX_W-1:0]       total;

   assign accept   = req_valid && req_ready;
   assign out_free = !rvalid_ff || rsp_ready;
   assign start    = accept;
   assign neg_val  = ~req_value + VALUE_WIDTH'(1);

   // saturate the configured base
   always_comb begin
      cfg_sat = cfg_base_ff;
      if (cfg_base_ff < BASE_MIN) begin
         cfg_sat = BASE_MIN;
      end else if (cfg_base_ff > BASE_MAX) begin
         cfg_sat = BASE_MAX;
      end
   end

   // enable token row: cell 0 steps while bits are fed, each higher cell on the registered enable of the cell below
   always_comb begin
      run[0] = (state_ff == ST_CONV) && (cnt_ff < CNT_FEED_END);
      for (int k = 1; k < VALUE_WIDTH; k++) begin
         run[k] = runsh_ff[k-1];
      end
      fin = runsh_ff & ~run;
   end

   assign nd_eff = (ndig_ff == '0) ? ND_W'(1) : ndig_ff;
   assign total  = IDX_W'(nd_eff) + IDX_W'(1) + IDX_W'(minus_ff);
   assign shift  = (state_ff == ST_EMIT) && out_free && (idx_ff != '0)
                   && (idx_ff <= IDX_W'(nd_eff));

   // digit cell row
   for (genvar k = 0; k < VALUE_WIDTH; k++) begin : g_cell
      digit_type sin;
      logic      cin;
      if (k == VALUE_WIDTH-1) begin : g_top
         assign sin = '0;
      end else begin : g_mid
         assign sin = digits[k+1];
      end
      if (k == 0) begin : g_first
         assign cin = mag_ff[VALUE_WIDTH-1];
      end else begin : g_rest
         assign cin = carry[k-1];
      end
      ditc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (start),
         .step_en   (run[k]),
         .carry_in  (cin),
         .base      (base_ff),
         .shift_en  (shift),
         .shift_in  (sin),
         .digit     (digits[k]),
         .carry_out (carry[k])
      );
      assign nz[k] = (digits[k] != '0);
   end

   // sequencer and output register
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mag_in    = mag_ff;
      minus_in  = minus_ff;
      base_in   = base_ff;
      ndig_in   = ndig_ff;
      idx_in    = idx_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      rchar_in  = rchar_ff;
      rlast_in  = rlast_ff;
      rlen_in   = rlen_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               minus_in = req_value[VALUE_WIDTH-1] && (cfg_sat == BASE_TEN);
               mag_in   = minus_in ? neg_val : req_value;
               base_in  = cfg_sat;
               cnt_in   = '0;
               ndig_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            if ((fin & nz) != '0) begin
               ndig_in = ND_W'(cnt_ff - CNT_FEED_END + CNT_W'(1));
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               if (idx_ff == '0) begin
                  rchar_in = CHAR_NUL;
               end else if (idx_ff <= IDX_W'(nd_eff)) begin
                  rchar_in = digit_char(digits[0]);
               end else begin
                  rchar_in = CHAR_MINUS;
               end
               rlast_in = (idx_ff == total - IDX_W'(1));
               rlen_in  = rlast_in ? TLEN_W'(total) : '0;
               idx_in   = idx_ff + IDX_W'(1);
               if (rlast_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register write
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      cfg_base_in = cfg_base_ff;
      if (cfg_wr && (csr_paddr[2] == REG_NUMBER_BASE)) begin
         cfg_base_in = csr_pwdata[BASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      minus_ff <= minus_in;
      base_ff  <= base_in;
      ndig_ff  <= ndig_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      rchar_ff <= rchar_in;
      rlast_ff <= rlast_in;
      rlen_ff  <= rlen_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         runsh_ff    <= '0;
         rvalid_ff   <= 1'b0;
         cfg_base_ff <= BASE_RESET;
      end else begin
         state_ff    <= state_in;
         runsh_ff    <= run;
         rvalid_ff   <= rvalid_in;
         cfg_base_ff <= cfg_base_in;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rvalid_ff;
   assign rsp_character    = rchar_ff;
   assign rsp_is_last      = rlast_ff;
   assign rsp_total_length = rlen_ff;
   assign csr_pready       = 1'b1;
   assign csr_prdata       = (csr_paddr[2] == REG_NUMBER_BASE)
                             ? {26'd0, cfg_base_ff} : 32'd0;

endmodule

@@ hdl/ditc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ditc_cell
// One digit of the conversion chain: doubles its digit and adds the carry
// from its lower neighbor, reducing modulo the base; also shifts digits down.
// ----------------------------------------------------------------------------
module ditc_cell
   import ditc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      clear,
   input  logic      step_en,
   input  logic      carry_in,
   input  digit_type base,
   input  logic      shift_en,
   input  digit_type shift_in,
   output digit_type digit,
   output logic      carry_out
);

   digit_type          digit_ff, digit_in;
   logic               carry_ff, carry_in_nxt;
   logic [BASE_W:0]    dbl;
   logic               over;

   // double and add carry, reduce once
   always_comb begin
      dbl          = {digit_ff, carry_in};
      over         = (dbl >= {1'b0, base});
      digit_in     = digit_ff;
      carry_in_nxt = 1'b0;
      if (clear) begin
         digit_in = '0;
      end else if (step_en) begin
         digit_in     = over ? BASE_W'(dbl - {1'b0, base}) : BASE_W'(dbl);
         carry_in_nxt = over;
      end else if (shift_en) begin
         digit_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      if (reset) begin
         carry_ff <= 1'b0;
      end else begin
         carry_ff <= clear ? 1'b0 : carry_in_nxt;
      end
   end

   assign digit     = digit_ff;
   assign carry_out = carry_ff;

endmodule

@@ hdl/ditc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ditc_checker
// Port-level checks for int_to_digit_string, bound to the top level.
// ----------------------------------------------------------------------------
module ditc_checker
   import ditc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_character,
   input logic              rsp_is_last,
   input logic [TLEN_W-1:0] rsp_total_length
);

   // hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character))
      else $error("stalled result changed");

   // only the final character carries a length
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> rsp_total_length == '0)
      else $error("length on non-final character");

   // a run is at least NUL plus one digit
   a_len_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |-> rsp_total_length >= TLEN_W'(2))
      else $error("run too short");

   // one value in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second value accepted during conversion");

   // output is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind int_to_digit_string ditc_checker u_ditc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_character    (rsp_character),
   .rsp_is_last      (rsp_is_last),
   .rsp_total_length (rsp_total_length)
);

@@ tb/int_to_digit_string_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_digit_string_test
// Self-checking bench for the integer to digit string converter. A directed
// table runs first in base ten after reset. Random values then run across
// several radix settings, the saturating extremes among them. Both channels
// idle at random. Every character is checked against a local conversion
// model.
// ----------------------------------------------------------------------------
module int_to_digit_string_test;
   import ditc_pkg::*;

   localparam int CYCLE_LIMIT = 5000000;
   localparam int ITEMS_PER_PHASE = 23;
   localparam int DRAIN_CYCLES = 120;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic [TLEN_W-1:0] len;
   } char_exp_type;

   typedef struct {
      logic [31:0]       value;
      logic [TLEN_W-1:0] len;   // typed run length, 0 where the model decides
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [31:0]         req_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CHAR_W-1:0]   rsp_character;
   logic                rsp_is_last;
   logic [TLEN_W-1:0]   rsp_total_length;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [2:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   char_exp_type        chars_due[$];
   logic [TLEN_W-1:0]   len_override[$];
   logic [BASE_W-1:0]   radix_reg;
   int                  errors;
   int                  cycles;
   int                  values_sent;
   int                  chars_seen;
   bit                  calm;

   int_to_digit_string dut (.*);

   // generate the clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // count cycles and stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // expected characters of one value at the current radix
   function automatic void convert_value(input logic [31:0] v, input logic [TLEN_W-1:0] tlen);
      logic [BASE_W-1:0] b;
      logic [31:0]       mag;
      logic [31:0]       d;
      logic              minus;
      logic [CHAR_W-1:0] run[$];
      char_exp_type      e;
      b = radix_reg;
      if (b < BASE_MIN) b = BASE_MIN;
      if (b > BASE_MAX) b = BASE_MAX;
      run.push_back(CHAR_NUL);
      if (v == 0) begin
         run.push_back(CHAR_ZERO);
      end else begin
         minus = v[31] && (b == BASE_TEN);
         mag = minus ? (32'd0 - v) : v;
         while (mag != 0) begin
            d = mag % b;
            if (d > DIGIT_NINE) run.push_back(CHAR_LOWA + d[7:0] - 8'd10);
            else run.push_back(CHAR_ZERO + d[7:0]);
            mag = mag / b;
         end
         if (minus) run.push_back(CHAR_MINUS);
      end
      for (int k = 0; k < run.size(); k++) begin
         e.ch   = run[k];
         e.last = (k == run.size() - 1);
         e.len  = e.last ? ((tlen != 0) ? tlen : TLEN_W'(run.size())) : '0;
         chars_due.push_back(e);
      end
   endfunction

   // predict on each accepted value, check each accepted character
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         convert_value(req_value, (len_override.size() > 0) ? len_override.pop_front() : '0);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         chars_seen++;
         if (chars_due.size() == 0) begin
            $error("unexpected character %h", rsp_character);
            errors++;
         end else begin
            char_exp_type e;
            e = chars_due.pop_front();
            if (rsp_character !== e.ch) begin
               $error("character: expected %h actual %h", e.ch, rsp_character);
               errors++;
            end
            if (rsp_is_last !== e.last) begin
               $error("is_last: expected %b actual %b", e.last, rsp_is_last);
               errors++;
            end
            if (rsp_total_length !== e.len) begin
               $error("total_length: expected %0d actual %0d", e.len, rsp_total_length);
               errors++;
            end
         end
      end
   end

   // receiver: stall at random, hold steady in calm phases
   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 3);
         end
      end
   end

   // write one register through the config port
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == 3'd0) radix_reg = data[BASE_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // read the radix back and compare with the local copy
   task automatic csr_check_radix();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= 3'd0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[BASE_W-1:0] !== radix_reg) begin
         $error("number_base: expected %0d actual %0d", radix_reg, csr_prdata[BASE_W-1:0]);
         errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // offer one value after a random gap and hold it until taken;
   // valid drops at a next call that has a gap, or at drain
   task automatic send_value(input logic [31:0] v);
      int gap;
      gap = calm ? 0 : (($urandom_range(0, 24) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 2));
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      values_sent++;
   endtask

   // drop the request, wait until every character is in, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (chars_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return $urandom_range(0, 40);
         2: return 32'd0 - $urandom_range(1, 40);
         3: case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'hffff_ffff;
               default: return 32'h0000_0001;
            endcase
         default: return $urandom;
      endcase
   endfunction

   dir_row_type dir_rows[] = '{
      '{32'd0, 6'd2}, '{32'd1, 6'd2}, '{32'hffff_ffff, 6'd3}, '{32'd9, 6'd2},
      '{32'd10, 6'd3}, '{32'hffff_fff6, 6'd4}, '{32'h7fff_ffff, 6'd11},
      '{32'h8000_0000, 6'd12}, '{32'd1000000000, 6'd11}, '{32'h1234_5678, 6'd0},
      '{32'hdead_beef, 6'd0}, '{32'haaaa_aaaa, 6'd0}, '{32'h5555_5555, 6'd0}
   };

   logic [BASE_W-1:0] radix_plan[] = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd7, 6'd10, 6'd16,
                                        6'd35, 6'd36, 6'd63};

   // main sequence
   initial begin
      logic [BASE_W-1:0] r;
      errors = 0; cycles = 0; values_sent = 0; chars_seen = 0; calm = 0;
      radix_reg = BASE_RESET;
      reset = 1'b1;
      req_valid = 1'b0; req_value = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table in the reset radix
      csr_check_radix();
      foreach (dir_rows[i]) begin
         len_override.push_back(dir_rows[i].len);
         send_value(dir_rows[i].value);
      end
      drain();

      // a write to an unmapped address leaves the radix alone
      csr_write(3'd4, 32'd16);
      csr_check_radix();
      send_value(32'hffff_ff85);
      drain();

      // random phases over the planned radices, then a few random ones
      for (int p = 0; p < radix_plan.size() + 3; p++) begin
         r = (p < radix_plan.size()) ? radix_plan[p] : BASE_W'($urandom_range(0, 63));
         csr_write(3'd0, {26'($urandom), r});
         csr_check_radix();
         calm = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_value(pick_value());
         drain();
      end
      calm = 0;

      // final settle with a bound on stray output
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Converted %0d values into %0d characters over %0d radix settings.",
               values_sent, chars_seen, radix_plan.size() + 4);
      $display("Left over expectations: %0d, mismatches: %0d.", chars_due.size(), errors);
      if (chars_due.size() != 0) errors++;
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
